### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the element volume checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### src/q4ev_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q4ev_pkg
// types and constants for the bilinear quad element volume pipeline
// ----------------------------------------------------------------------------
package q4ev_pkg;

   // corner coordinate width, signed Q.16
   localparam int COORD_WIDTH = 32;

   localparam int THICK_W     = 32;
   localparam int VOLUME_W    = 63;
   localparam int VOL_FRAC    = 16;

   // gauss abscissa 1/sqrt(3) in Q0.24
   localparam int GAUSS_W    = 24;
   localparam int GAUSS_FRAC = 24;
   localparam logic [GAUSS_W-1:0] GAUSS_Q24 = 24'd9686330;

   localparam logic [THICK_W-1:0]  THICK_RESET = 32'd65536;
   localparam logic [VOLUME_W-1:0] VOLUME_MAX  = {VOLUME_W{1'b1}};

   // derived datapath widths
   localparam int EDGE_W   = COORD_WIDTH + 2;
   localparam int PROD_W   = 2 * EDGE_W;
   localparam int COEF_W   = PROD_W + 1;
   localparam int DIFF_W   = COEF_W + 1;
   localparam int MAG_W    = DIFF_W;
   localparam int SPLIT_LO = (MAG_W + 1) / 2;
   localparam int SPLIT_HI = MAG_W - SPLIT_LO;
   localparam int PP_LO_W  = SPLIT_LO + GAUSS_W;
   localparam int PP_HI_W  = SPLIT_HI + GAUSS_W;
   localparam int TERM_W   = MAG_W + GAUSS_W;
   localparam int SUM_W    = TERM_W + 1;
   // four |T| sum to twice the two maxima, so one bit less of shift
   localparam int AREA_SHIFT = 43;
   localparam int AREA_W   = SUM_W - AREA_SHIFT;
   localparam int AREA_LO  = (AREA_W + 1) / 2;
   localparam int AREA_HI  = AREA_W - AREA_LO;
   localparam int APP_LO_W = AREA_LO + THICK_W;
   localparam int APP_HI_W = AREA_HI + THICK_W;
   localparam int VPROD_W  = AREA_W + THICK_W;
   localparam int RES_W    = VPROD_W - VOL_FRAC;
   localparam int EXT_W    = (RES_W > VOLUME_W + 1) ? RES_W : VOLUME_W + 1;

   localparam int NUM_STAGES = 11;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] node0_x;
      logic signed [COORD_WIDTH-1:0] node0_y;
      logic signed [COORD_WIDTH-1:0] node1_x;
      logic signed [COORD_WIDTH-1:0] node1_y;
      logic signed [COORD_WIDTH-1:0] node2_x;
      logic signed [COORD_WIDTH-1:0] node2_y;
      logic signed [COORD_WIDTH-1:0] node3_x;
      logic signed [COORD_WIDTH-1:0] node3_y;
   } q4ev_req_type;

   typedef struct packed {
      logic [VOLUME_W-1:0] volume;
      logic                saturated;
   } q4ev_rsp_type;

endpackage

### src/q4_element_volume.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q4_element_volume
// area times thickness of a bilinear quad from 2x2 gauss jacobian determinants
// ----------------------------------------------------------------------------
//  channel | dir | word
//  req_    | in  | four corners, signed Q.16 x and y each
//  rsp_    | out | volume Q47.16 and saturated flag
//  csr_    | in  | thickness, unsigned Q16.16, write only
//
//  one element per cycle unless a stall on rsp_ backs the pipeline up; the
//  accepting edge loads the first of eleven register stages (edges, products,
//  coefficients, sums, magnitudes, gauss partials, terms, maxima, area,
//  thickness partials, output), and the result shows on rsp_ from the last.
//  reset is synchronous and clears valid bits; thickness returns to 1.0.
//  a stage loads when it is empty or the stage after it moves, so bubbles
//  close up and a stalled output word holds while earlier stages fill.
// ----------------------------------------------------------------------------
module q4_element_volume (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  q4ev_pkg::q4ev_req_type   req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output q4ev_pkg::q4ev_rsp_type   rsp_data,
   input  logic                     csr_wr_en,
   input  logic [q4ev_pkg::THICK_W-1:0] csr_wr_data
);
   import q4ev_pkg::*;

   logic [THICK_W-1:0]    thickness_ff;
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] rdy;

   // stage 1: edge vectors
   logic signed [EDGE_W-1:0] s1_ex_in, s1_fx_in, s1_gx_in, s1_ey_in, s1_fy_in, s1_gy_in;
   logic signed [EDGE_W-1:0] s1_ex_ff, s1_fx_ff, s1_gx_ff, s1_ey_ff, s1_fy_ff, s1_gy_ff;
   // stage 2: cross products
   logic signed [PROD_W-1:0] s2_exfy_ff, s2_fxey_ff, s2_exgy_ff;
   logic signed [PROD_W-1:0] s2_gxey_ff, s2_gxfy_ff, s2_fxgy_ff;
   // stage 3: determinant coefficients
   logic signed [COEF_W-1:0] s3_c0_ff, s3_c1_ff, s3_c2_ff;
   // stage 4: c1 +/- c2 and |c0|
   logic signed [DIFF_W-1:0] s4_dp_ff, s4_dm_ff;
   logic [COEF_W-1:0]        s4_c0mag_in, s4_c0mag_ff;
   // stage 5: magnitudes
   logic [MAG_W-1:0]         s5_mp_in, s5_mm_in, s5_mp_ff, s5_mm_ff;
   logic [COEF_W-1:0]        s5_c0mag_ff;
   // stage 6: gauss partial products
   logic [PP_LO_W-1:0]       s6_plo_ff, s6_mlo_ff;
   logic [PP_HI_W-1:0]       s6_phi_ff, s6_mhi_ff;
   logic [COEF_W-1:0]        s6_c0mag_ff;
   // stage 7: full terms
   logic [TERM_W-1:0]        s7_a_ff, s7_bp_ff, s7_bm_ff;
   // stage 8: maxima
   logic [TERM_W-1:0]        s8_maxp_ff, s8_maxm_ff;
   // stage 9: area
   logic [SUM_W-1:0]         s9_sum_in;
   logic [AREA_W-1:0]        s9_area_ff;
   // stage 10: thickness partials
   logic [APP_LO_W-1:0]      s10_lo_ff;
   logic [APP_HI_W-1:0]      s10_hi_ff;
   // stage 11: output
   logic [VPROD_W-1:0]       s11_prod_in;
   logic [EXT_W-1:0]         s11_ext_in;
   logic                     s11_sat_in;
   q4ev_rsp_type             rsp_data_in, rsp_data_ff;

   // ready chain from the output back to the input
   always_comb begin
      rdy[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   assign req_stall = !rdy[0];
   assign rsp_valid = vld_ff[NUM_STAGES-1];
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         thickness_ff <= THICK_RESET;
      end else begin
         if (csr_wr_en) begin
            thickness_ff <= csr_wr_data;
         end
         if (rdy[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   always_comb begin
      s1_ex_in = EDGE_W'(req_data.node1_x) + EDGE_W'(req_data.node2_x)
               - EDGE_W'(req_data.node0_x) - EDGE_W'(req_data.node3_x);
      s1_fx_in = EDGE_W'(req_data.node2_x) + EDGE_W'(req_data.node3_x)
               - EDGE_W'(req_data.node0_x) - EDGE_W'(req_data.node1_x);
      s1_gx_in = EDGE_W'(req_data.node0_x) + EDGE_W'(req_data.node2_x)
               - EDGE_W'(req_data.node1_x) - EDGE_W'(req_data.node3_x);
      s1_ey_in = EDGE_W'(req_data.node1_y) + EDGE_W'(req_data.node2_y)
               - EDGE_W'(req_data.node0_y) - EDGE_W'(req_data.node3_y);
      s1_fy_in = EDGE_W'(req_data.node2_y) + EDGE_W'(req_data.node3_y)
               - EDGE_W'(req_data.node0_y) - EDGE_W'(req_data.node1_y);
      s1_gy_in = EDGE_W'(req_data.node0_y) + EDGE_W'(req_data.node2_y)
               - EDGE_W'(req_data.node1_y) - EDGE_W'(req_data.node3_y);
   end

   always_comb begin
      s4_c0mag_in = s3_c0_ff[COEF_W-1] ? COEF_W'(-s3_c0_ff) : COEF_W'(s3_c0_ff);
      s5_mp_in    = s4_dp_ff[DIFF_W-1] ? MAG_W'(-s4_dp_ff) : MAG_W'(s4_dp_ff);
      s5_mm_in    = s4_dm_ff[DIFF_W-1] ? MAG_W'(-s4_dm_ff) : MAG_W'(s4_dm_ff);
      // |A-B| + |A+B| = 2 max(|A|,|B|), so only the maxima are summed
      s9_sum_in   = SUM_W'(s8_maxp_ff) + SUM_W'(s8_maxm_ff);
      s11_prod_in = (VPROD_W'(s10_hi_ff) << AREA_LO) + VPROD_W'(s10_lo_ff);
      s11_ext_in  = EXT_W'(s11_prod_in[VPROD_W-1:VOL_FRAC]);
      s11_sat_in  = |s11_ext_in[EXT_W-1:VOLUME_W];
      rsp_data_in.saturated = s11_sat_in;
      rsp_data_in.volume    = s11_sat_in ? VOLUME_MAX : s11_ext_in[VOLUME_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         s1_ex_ff <= s1_ex_in;
         s1_fx_ff <= s1_fx_in;
         s1_gx_ff <= s1_gx_in;
         s1_ey_ff <= s1_ey_in;
         s1_fy_ff <= s1_fy_in;
         s1_gy_ff <= s1_gy_in;
      end
      if (rdy[1]) begin
         s2_exfy_ff <= PROD_W'(s1_ex_ff) * PROD_W'(s1_fy_ff);
         s2_fxey_ff <= PROD_W'(s1_fx_ff) * PROD_W'(s1_ey_ff);
         s2_exgy_ff <= PROD_W'(s1_ex_ff) * PROD_W'(s1_gy_ff);
         s2_gxey_ff <= PROD_W'(s1_gx_ff) * PROD_W'(s1_ey_ff);
         s2_gxfy_ff <= PROD_W'(s1_gx_ff) * PROD_W'(s1_fy_ff);
         s2_fxgy_ff <= PROD_W'(s1_fx_ff) * PROD_W'(s1_gy_ff);
      end
      if (rdy[2]) begin
         s3_c0_ff <= COEF_W'(s2_exfy_ff) - COEF_W'(s2_fxey_ff);
         s3_c1_ff <= COEF_W'(s2_exgy_ff) - COEF_W'(s2_gxey_ff);
         s3_c2_ff <= COEF_W'(s2_gxfy_ff) - COEF_W'(s2_fxgy_ff);
      end
      if (rdy[3]) begin
         s4_dp_ff    <= DIFF_W'(s3_c1_ff) + DIFF_W'(s3_c2_ff);
         s4_dm_ff    <= DIFF_W'(s3_c1_ff) - DIFF_W'(s3_c2_ff);
         s4_c0mag_ff <= s4_c0mag_in;
      end
      if (rdy[4]) begin
         s5_mp_ff    <= s5_mp_in;
         s5_mm_ff    <= s5_mm_in;
         s5_c0mag_ff <= s4_c0mag_ff;
      end
      if (rdy[5]) begin
         s6_plo_ff   <= PP_LO_W'(s5_mp_ff[SPLIT_LO-1:0]) * PP_LO_W'(GAUSS_Q24);
         s6_phi_ff   <= PP_HI_W'(s5_mp_ff[MAG_W-1:SPLIT_LO]) * PP_HI_W'(GAUSS_Q24);
         s6_mlo_ff   <= PP_LO_W'(s5_mm_ff[SPLIT_LO-1:0]) * PP_LO_W'(GAUSS_Q24);
         s6_mhi_ff   <= PP_HI_W'(s5_mm_ff[MAG_W-1:SPLIT_LO]) * PP_HI_W'(GAUSS_Q24);
         s6_c0mag_ff <= s5_c0mag_ff;
      end
      if (rdy[6]) begin
         s7_a_ff  <= TERM_W'(s6_c0mag_ff) << GAUSS_FRAC;
         s7_bp_ff <= (TERM_W'(s6_phi_ff) << SPLIT_LO) + TERM_W'(s6_plo_ff);
         s7_bm_ff <= (TERM_W'(s6_mhi_ff) << SPLIT_LO) + TERM_W'(s6_mlo_ff);
      end
      if (rdy[7]) begin
         s8_maxp_ff <= (s7_a_ff >= s7_bp_ff) ? s7_a_ff : s7_bp_ff;
         s8_maxm_ff <= (s7_a_ff >= s7_bm_ff) ? s7_a_ff : s7_bm_ff;
      end
      if (rdy[8]) begin
         s9_area_ff <= s9_sum_in[SUM_W-1:AREA_SHIFT];
      end
      if (rdy[9]) begin
         s10_lo_ff <= APP_LO_W'(s9_area_ff[AREA_LO-1:0]) * APP_LO_W'(thickness_ff);
         s10_hi_ff <= APP_HI_W'(s9_area_ff[AREA_W-1:AREA_LO]) * APP_HI_W'(thickness_ff);
      end
      if (rdy[10]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

### src/q4ev_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q4ev_checker
// port-level checks for the element volume pipeline, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module q4ev_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input q4ev_pkg::q4ev_req_type   req_data,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input q4ev_pkg::q4ev_rsp_type   rsp_data,
   input logic                     csr_wr_en,
   input logic [q4ev_pkg::THICK_W-1:0] csr_wr_data
);
   import q4ev_pkg::*;

   logic out_free;
   logic in_word;
   logic cfg_word;

   assign out_free = !rsp_valid || !rsp_stall;
   assign in_word  = req_valid && (req_data == req_data);
   assign cfg_word = csr_wr_en && (csr_wr_data == csr_wr_data);

   // a stalled output word holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   // a clamped volume is always the full-scale value
   `ASSERT_SAME(a_sat_max, clock, reset, rsp_valid && rsp_data.saturated, rsp_data.volume == VOLUME_MAX)
   // an output that is free to move never backs up the input
   `ASSERT_SAME(a_no_false_stall, clock, reset, out_free, !req_stall)
   // req_stall never sees unknowns while the input or config port is in use
   `ASSERT_SAME(a_known_ports, clock, reset, in_word || cfg_word, !$isunknown(req_stall))

endmodule

bind q4_element_volume q4ev_checker u_q4ev_checker (.*);

### verif/tb_q4_element_volume.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_q4_element_volume
// self-checking bench for the q4 element volume pipeline
// ----------------------------------------------------------------------------
// A scoreboard predicts each volume with exact 128-bit arithmetic from the
// four corners and the current thickness. Every accepted result is compared
// field by field with the oldest prediction. Directed corner cases come
// first, at the reset thickness and at full-scale thickness. Random elements
// follow under several thickness settings, with random idling on both
// channels and long receiver hold-offs that back the pipeline up.
// ----------------------------------------------------------------------------
module tb_q4_element_volume;
   import q4ev_pkg::*;

   localparam int PIPE_DEPTH     = 11;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_ITEMS    = 180;
   localparam logic [31:0] Q_ONE  = 32'h0001_0000;
   localparam logic [31:0] C_MAX  = 32'h7FFF_FFFF;
   localparam logic [31:0] C_MIN  = 32'h8000_0000;
   localparam logic signed [127:0] GAUSS_G   = 128'sd9686330;
   localparam logic signed [127:0] GAUSS_ONE = 128'sd16777216;

   class element_volume_board;
      q4ev_rsp_type want_q[$];
      logic [THICK_W-1:0] thickness;
      int taken;
      int checked;
      int mismatches;

      function new();
         thickness  = THICK_RESET;
         taken      = 0;
         checked    = 0;
         mismatches = 0;
      endfunction

      function logic signed [127:0] widen(logic [31:0] v);
         return {{96{v[31]}}, v};
      endfunction

      function logic [127:0] magnitude(logic signed [127:0] t);
         return t[127] ? -t : t;
      endfunction

      function q4ev_rsp_type predict_volume(q4ev_req_type e);
         logic signed [127:0] x0, y0, x1, y1, x2, y2, x3, y3;
         logic signed [127:0] ex, fx, gx, ey, fy, gy;
         logic signed [127:0] c0, c1, c2, base, p1, p2;
         logic [127:0] s, area, prod, scaled;
         q4ev_rsp_type r;
         x0 = widen(e.node0_x);
         y0 = widen(e.node0_y);
         x1 = widen(e.node1_x);
         y1 = widen(e.node1_y);
         x2 = widen(e.node2_x);
         y2 = widen(e.node2_y);
         x3 = widen(e.node3_x);
         y3 = widen(e.node3_y);
         ex = x1 + x2 - x0 - x3;
         fx = x2 + x3 - x0 - x1;
         gx = x0 + x2 - x1 - x3;
         ey = y1 + y2 - y0 - y3;
         fy = y2 + y3 - y0 - y1;
         gy = y0 + y2 - y1 - y3;
         c0 = ex * fy - fx * ey;
         c1 = ex * gy - gx * ey;
         c2 = gx * fy - fx * gy;
         base = c0 * GAUSS_ONE;
         p1 = c1 * GAUSS_G;
         p2 = c2 * GAUSS_G;
         // one term per gauss point, signs of xi and eta
         s = magnitude(base - p1 - p2) + magnitude(base + p1 - p2)
           + magnitude(base - p1 + p2) + magnitude(base + p1 + p2);
         area   = s >> 44;
         prod   = area * {96'd0, thickness};
         scaled = prod >> 16;
         if (scaled[127:63] != '0) begin
            r.volume    = '1;
            r.saturated = 1'b1;
         end else begin
            r.volume    = scaled[62:0];
            r.saturated = 1'b0;
         end
         return r;
      endfunction

      function void note_element(q4ev_req_type e);
         want_q.push_back(predict_volume(e));
         taken++;
      endfunction

      function void check_volume(q4ev_rsp_type got);
         q4ev_rsp_type w;
         checked++;
         if (want_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word: volume %h saturated %b",
                        got.volume, got.saturated);
         end else begin
            w = want_q.pop_front();
            if (got.volume !== w.volume || got.saturated !== w.saturated) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: volume exp %h got %h, saturated exp %b got %b",
                           checked, w.volume, got.volume, w.saturated, got.saturated);
            end
         end
      endfunction
   endclass

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   q4ev_req_type       req_data    = '0;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   q4ev_rsp_type       rsp_data;
   logic               csr_wr_en   = 1'b0;
   logic [THICK_W-1:0] csr_wr_data = '0;

   element_volume_board sb = new();

   q4_element_volume u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic q4ev_req_type make_quad(logic [31:0] x0, logic [31:0] y0,
                                              logic [31:0] x1, logic [31:0] y1,
                                              logic [31:0] x2, logic [31:0] y2,
                                              logic [31:0] x3, logic [31:0] y3);
      q4ev_req_type e;
      e.node0_x = x0;
      e.node0_y = y0;
      e.node1_x = x1;
      e.node1_y = y1;
      e.node2_x = x2;
      e.node2_y = y2;
      e.node3_x = x3;
      e.node3_y = y3;
      return e;
   endfunction

   function automatic logic [31:0] corner_pick();
      case ($urandom_range(0, 4))
         0:       return C_MIN;
         1:       return C_MAX;
         2:       return 32'd0;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic q4ev_req_type rand_element();
      logic [31:0] cx, cy, w, h, j0, j1, j2, j3, j4, j5;
      int sh, pick;
      q4ev_req_type e;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         // well-formed quad: a jittered rectangle of random size and place
         sh = $urandom_range(0, 31);
         cx = $urandom;
         cy = $urandom;
         w  = ($urandom >> (31 - sh)) | 32'd1;
         h  = ($urandom >> (31 - $urandom_range(0, sh))) | 32'd1;
         j0 = $urandom % ((w >> 2) + 1);
         j1 = $urandom % ((h >> 2) + 1);
         j2 = $urandom % ((w >> 2) + 1);
         j3 = $urandom % ((h >> 2) + 1);
         j4 = $urandom % ((w >> 2) + 1);
         j5 = $urandom % ((h >> 2) + 1);
         if ($urandom_range(0, 1))
            e = make_quad(cx, cy, cx + w + j0, cy + j1,
                          cx + w + j2, cy + h + j3, cx + j4, cy + h + j5);
         else
            e = make_quad(cx, cy, cx + j4, cy + h + j5,
                          cx + w + j2, cy + h + j3, cx + w + j0, cy + j1);
      end else if (pick < 85) begin
         e = make_quad($urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom);
      end else begin
         e = make_quad(corner_pick(), corner_pick(), corner_pick(), corner_pick(),
                       corner_pick(), corner_pick(), corner_pick(), corner_pick());
      end
      return e;
   endfunction

   task automatic send_element(input q4ev_req_type e);
      int gap;
      gap = 0;
      // no idling on the sender across a stretch in the middle of the run
      if (!(sb.taken >= 400 && sb.taken < 600) && $urandom_range(0, 99) < 8)
         gap = $urandom_range(1, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= e;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_element(e);
   endtask

   task automatic write_thickness(input logic [THICK_W-1:0] v);
      req_valid <= 1'b0;
      while (sb.want_q.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      sb.thickness  = v;
   endtask

   task automatic run_directed();
      send_element(make_quad(0, 0, 0, 0, 0, 0, 0, 0));
      send_element(make_quad(0, 0, Q_ONE, 0, Q_ONE, Q_ONE, 0, Q_ONE));
      // clockwise order, negative determinant
      send_element(make_quad(0, 0, 0, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 0));
      // folded bowtie
      send_element(make_quad(0, 0, Q_ONE, Q_ONE, Q_ONE, 0, 0, Q_ONE));
      // collinear corners, zero area
      send_element(make_quad(0, 0, Q_ONE, 0, 2 * Q_ONE, 0, 3 * Q_ONE, 0));
      send_element(make_quad(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
      send_element(make_quad(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
      // full-range square, both orientations
      send_element(make_quad(C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX));
      send_element(make_quad(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX, C_MIN));
      send_element(make_quad(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
                             32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA));
      send_element(make_quad(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0));
      // irregular convex quad with fractional corners
      send_element(make_quad(0, 0, 32'h0003_8000, 0, 32'h0002_4000, 32'h0001_C000,
                             32'h0000_8000, 32'h0002_0000));
      send_element(make_quad(C_MAX, 0, C_MIN, 0, C_MIN, C_MAX, C_MAX, C_MAX));
   endtask

   initial begin : stimulus
      logic [THICK_W-1:0] plan [6];
      plan[0] = 32'd0;
      plan[1] = 32'd1;
      plan[2] = 32'hFFFF_FFFF;
      plan[3] = $urandom;
      plan[4] = $urandom_range(0, 4 * Q_ONE);
      plan[5] = Q_ONE;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      write_thickness(32'hFFFF_FFFF);
      run_directed();
      for (int p = 0; p < 6; p++) begin
         write_thickness(plan[p]);
         repeat (PHASE_ITEMS) send_element(rand_element());
      end
      req_valid <= 1'b0;
      while (sb.want_q.size() != 0) @(posedge clock);
      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (sb.mismatches == 0 && sb.want_q.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin : result_side
      int hold_left;
      int next_squeeze;
      hold_left    = 0;
      next_squeeze = 100;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall)
            sb.check_volume(rsp_data);
         // long hold-off while the sender keeps going, fills the pipeline
         if (hold_left == 0 && sb.taken >= next_squeeze) begin
            hold_left    = 300;
            next_squeeze = next_squeeze + 550;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (sb.checked >= 450 && sb.checked < 700) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 15);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("Test completed with failures");
      $finish;
   end

endmodule
